[rtl/bezier_outline_flattener_top_macros.svh]
// Assertion macros shared by the outline flattener RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BEZIER_OUTLINE_FLATTENER_TOP_MACROS_SVH
`define BEZIER_OUTLINE_FLATTENER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BOF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BOF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bof_pkg.sv]
// Types and constants shared by the outline flattener modules.
// No dependencies.
package bof_pkg;

  localparam int COORD_W     = 24;
  localparam int CMD_W       = 2;
  localparam int IN_DATA_W   = 6 * COORD_W;
  localparam int OUT_DATA_W  = 2 * COORD_W;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_QUAD  = 2'd2,
    CMD_CUBIC = 2'd3
  } cmd_kind_t;

  // One queued command, with the start point captured at acceptance.
  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [COORD_W-1:0]   p0_x;
    logic signed [COORD_W-1:0]   p0_y;
    logic signed [COORD_W-1:0]   a_x;
    logic signed [COORD_W-1:0]   a_y;
    logic signed [COORD_W-1:0]   b_x;
    logic signed [COORD_W-1:0]   b_y;
    logic signed [COORD_W-1:0]   e_x;
    logic signed [COORD_W-1:0]   e_y;
  } bof_cmd_t;

  typedef struct packed {
    logic start;
    logic last;
  } bof_flags_t;

endpackage

[rtl/bezier_outline_flattener_top.sv]
// The engine takes a new command only after the last point of the current
// one, and forms each point with its one shared multiplier per coordinate,
// stepped over four operands for each point.
// Reset clears the current point to (0,0), the command queue and the divider.

// Top level of the outline flattener: front end, command queue, point
// engine and divider. Depends on bof_pkg and the assertion macros.
`include "bezier_outline_flattener_top_macros.svh"

module bezier_outline_flattener_top
  import bof_pkg::*;
#(
  parameter int SEGMENTS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: point_x, point_y.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: path_start.
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int NW = $clog2(SEGMENTS + 1);
  localparam int WW = 3 * NW;
  localparam int RW = COORD_W + WW;

  logic          q_valid;
  logic          q_ready;
  bof_cmd_t      q_rec;
  logic          dv_valid;
  logic          dv_ready;
  logic [RW-1:0] dv_num_x;
  logic [RW-1:0] dv_num_y;
  logic [WW-1:0] dv_den;
  bof_flags_t    dv_flags;

  bof_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_rec         (q_rec)
  );

  bof_engine #(
    .SEGMENTS (SEGMENTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_rec    (q_rec),
    .dv_valid (dv_valid),
    .dv_ready (dv_ready),
    .dv_num_x (dv_num_x),
    .dv_num_y (dv_num_y),
    .dv_den   (dv_den),
    .dv_flags (dv_flags)
  );

  bof_divider #(
    .SEGMENTS (SEGMENTS)
  ) u_divider (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (dv_valid),
    .in_ready      (dv_ready),
    .in_num_x      (dv_num_x),
    .in_num_y      (dv_num_y),
    .in_den        (dv_den),
    .in_flags      (dv_flags),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A path start comes only from a move, which yields a single point.
  `BOF_ASSERT_IMPLIES(a_start_is_last, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "path start point without tlast")
  // Back-pressure at the input only when the queue holds work.
  `BOF_ASSERT_IMPLIES(a_stall_has_work, clk, rst, !s_axis_tready, q_valid, "input stalled with an empty queue")
  // The engine leaves idle on each command it takes, so it never takes two in a row.
  `BOF_ASSERT_NEXT(a_single_pop, clk, rst, q_valid && q_ready, !q_ready, "engine took two commands in a row")

endmodule

[rtl/bof_front.sv]
// Front end: accepts outline commands, tracks the current point and queues
// commands for the engine. Depends on bof_pkg.
module bof_front
  import bof_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y.
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: cmd.
  input  logic [CMD_W-1:0]     s_axis_tuser,
  output logic                 q_valid,
  input  logic                 q_ready,
  output bof_cmd_t             q_rec
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  bof_cmd_t                  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]          wr_ptr;
  logic [PTR_W-1:0]          rd_ptr;
  logic [CNT_W-1:0]          count;
  bof_cmd_t                  in_rec;
  logic                      push;
  logic                      pop;

  always_comb begin
    in_rec.kind = cmd_kind_t'(s_axis_tuser);
    in_rec.p0_x = cur_x;
    in_rec.p0_y = cur_y;
    in_rec.a_x  = $signed(s_axis_tdata[1*COORD_W-1:0*COORD_W]);
    in_rec.a_y  = $signed(s_axis_tdata[2*COORD_W-1:1*COORD_W]);
    in_rec.b_x  = $signed(s_axis_tdata[3*COORD_W-1:2*COORD_W]);
    in_rec.b_y  = $signed(s_axis_tdata[4*COORD_W-1:3*COORD_W]);
    in_rec.e_x  = $signed(s_axis_tdata[5*COORD_W-1:4*COORD_W]);
    in_rec.e_y  = $signed(s_axis_tdata[6*COORD_W-1:5*COORD_W]);
  end

  assign s_axis_tready = (count != FULL_CNT);
  assign q_valid       = (count != '0);
  assign q_rec         = mem[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid && q_ready;

  // The end point of every accepted command becomes the next start point.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x  <= '0;
      cur_y  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        cur_x       <= in_rec.e_x;
        cur_y       <= in_rec.e_y;
        mem[wr_ptr] <= in_rec;
        wr_ptr      <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/bof_engine.sv]
// Back-end sequencer: steps through the points of each command, forms the
// Bernstein weights and accumulates the weighted sums. Depends on bof_pkg.
module bof_engine
  import bof_pkg::*;
#(
  parameter int SEGMENTS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  bof_cmd_t                            q_rec,
  output logic                                dv_valid,
  input  logic                                dv_ready,
  output logic [COORD_W+3*$clog2(SEGMENTS+1)-1:0] dv_num_x,
  output logic [COORD_W+3*$clog2(SEGMENTS+1)-1:0] dv_num_y,
  output logic [3*$clog2(SEGMENTS+1)-1:0]     dv_den,
  output bof_flags_t                          dv_flags
);

  localparam int NW  = $clog2(SEGMENTS + 1);
  localparam int AAW = 2 * NW;
  localparam int WW  = 3 * NW;
  localparam int PW  = COORD_W + WW + 1;
  localparam int AW  = COORD_W + WW + 2;
  localparam int RW  = COORD_W + WW;

  localparam logic [NW-1:0] N_K = NW'(SEGMENTS);

  localparam longint DEN1 = 1;
  localparam longint DEN2 = longint'(SEGMENTS) * SEGMENTS;
  localparam longint DEN3 = DEN2 * SEGMENTS;

  localparam logic [WW-1:0] DEN_W1 = WW'(DEN1);
  localparam logic [WW-1:0] DEN_W2 = WW'(DEN2);
  localparam logic [WW-1:0] DEN_W3 = WW'(DEN3);

  // Half the divisor for rounding, plus an offset that keeps the dividend
  // non-negative for the unsigned divider.
  localparam logic signed [AW-1:0] BIAS1 = AW'(DEN1 / 2 + (DEN1 << (COORD_W - 1)));
  localparam logic signed [AW-1:0] BIAS2 = AW'(DEN2 / 2 + (DEN2 << (COORD_W - 1)));
  localparam logic signed [AW-1:0] BIAS3 = AW'(DEN3 / 2 + (DEN3 << (COORD_W - 1)));

  typedef enum logic [2:0] {
    S_IDLE,
    S_WGT1,
    S_WGT2,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM
  } eng_state_t;

  eng_state_t               st;
  bof_cmd_t                 rec;
  logic [NW-1:0]            k;
  logic [AAW-1:0]           aa;
  logic [AAW-1:0]           ab;
  logic [AAW-1:0]           bb;
  logic [WW-1:0]            w [4];
  logic signed [PW-1:0]     prod_x;
  logic signed [PW-1:0]     prod_y;
  logic signed [AW-1:0]     acc_x;
  logic signed [AW-1:0]     acc_y;

  logic [NW-1:0]            a_val;
  logic [WW-1:0]            w_next [4];
  logic [WW-1:0]            t_aab;
  logic [WW-1:0]            t_abb;
  logic [WW-1:0]            w_sel;
  logic signed [COORD_W-1:0] op_x;
  logic signed [COORD_W-1:0] op_y;
  logic signed [PW-1:0]     mul_x;
  logic signed [PW-1:0]     mul_y;
  logic signed [AW-1:0]     bias_sel;
  logic signed [AW-1:0]     sum_x;
  logic signed [AW-1:0]     sum_y;
  logic                     is_last;

  assign a_val = N_K - k;
  assign t_aab = WW'(aa) * WW'(k);
  assign t_abb = WW'(bb) * WW'(a_val);

  always_comb begin
    case (rec.kind)
      CMD_QUAD: begin
        w_next[0] = WW'(aa);
        w_next[1] = WW'(ab) << 1;
        w_next[2] = '0;
        w_next[3] = WW'(bb);
        bias_sel  = BIAS2;
        dv_den    = DEN_W2;
      end
      CMD_CUBIC: begin
        w_next[0] = WW'(aa) * WW'(a_val);
        w_next[1] = t_aab + (t_aab << 1);
        w_next[2] = t_abb + (t_abb << 1);
        w_next[3] = WW'(bb) * WW'(k);
        bias_sel  = BIAS3;
        dv_den    = DEN_W3;
      end
      default: begin
        // Move and line: the point is the end point itself.
        w_next[0] = '0;
        w_next[1] = '0;
        w_next[2] = '0;
        w_next[3] = DEN_W1;
        bias_sel  = BIAS1;
        dv_den    = DEN_W1;
      end
    endcase
  end

  // One shared multiplier per coordinate, stepped over the four operands.
  always_comb begin
    case (st)
      S_MUL0: begin
        op_x  = rec.p0_x;
        op_y  = rec.p0_y;
        w_sel = w[0];
      end
      S_MUL1: begin
        op_x  = rec.a_x;
        op_y  = rec.a_y;
        w_sel = w[1];
      end
      S_MUL2: begin
        op_x  = rec.b_x;
        op_y  = rec.b_y;
        w_sel = w[2];
      end
      default: begin
        op_x  = rec.e_x;
        op_y  = rec.e_y;
        w_sel = w[3];
      end
    endcase
  end

  assign mul_x = op_x * $signed({1'b0, w_sel});
  assign mul_y = op_y * $signed({1'b0, w_sel});

  assign sum_x   = acc_x + AW'(prod_x);
  assign sum_y   = acc_y + AW'(prod_y);
  assign is_last = (rec.kind == CMD_MOVE) || (rec.kind == CMD_LINE) || (k == N_K);

  assign q_ready        = (st == S_IDLE);
  assign dv_valid       = (st == S_SUM);
  assign dv_num_x       = sum_x[RW-1:0];
  assign dv_num_y       = sum_y[RW-1:0];
  assign dv_flags.start = (rec.kind == CMD_MOVE);
  assign dv_flags.last  = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: begin
          if (q_valid) begin
            rec <= q_rec;
            k   <= NW'(1);
            st  <= S_WGT1;
          end
        end
        S_WGT1: begin
          aa <= AAW'(a_val) * AAW'(a_val);
          ab <= AAW'(a_val) * AAW'(k);
          bb <= AAW'(k) * AAW'(k);
          st <= S_WGT2;
        end
        S_WGT2: begin
          w  <= w_next;
          st <= S_MUL0;
        end
        S_MUL0: begin
          prod_x <= mul_x;
          prod_y <= mul_y;
          st     <= S_MUL1;
        end
        S_MUL1: begin
          prod_x <= mul_x;
          prod_y <= mul_y;
          acc_x  <= AW'(prod_x) + bias_sel;
          acc_y  <= AW'(prod_y) + bias_sel;
          st     <= S_MUL2;
        end
        S_MUL2: begin
          prod_x <= mul_x;
          prod_y <= mul_y;
          acc_x  <= sum_x;
          acc_y  <= sum_y;
          st     <= S_MUL3;
        end
        S_MUL3: begin
          prod_x <= mul_x;
          prod_y <= mul_y;
          acc_x  <= sum_x;
          acc_y  <= sum_y;
          st     <= S_SUM;
        end
        S_SUM: begin
          if (dv_ready) begin
            if (is_last) begin
              st <= S_IDLE;
            end else begin
              k  <= k + NW'(1);
              st <= S_WGT1;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bof_divider.sv]
// Divider for the point sums: a reciprocal multiplication with one correction
// step, over the estimate, multiply and fix states, then the output register
// of the master stream. Depends on bof_pkg.
module bof_divider
  import bof_pkg::*;
#(
  parameter int SEGMENTS = 20
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [COORD_W+3*$clog2(SEGMENTS+1)-1:0] in_num_x,
  input  logic [COORD_W+3*$clog2(SEGMENTS+1)-1:0] in_num_y,
  input  logic [3*$clog2(SEGMENTS+1)-1:0]         in_den,
  input  bof_flags_t                              in_flags,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // Fields from bit 0: point_x, point_y.
  output logic [OUT_DATA_W-1:0]                   m_axis_tdata,
  // Fields from bit 0: path_start.
  output logic [0:0]                              m_axis_tuser,
  output logic                                    m_axis_tlast
);

  localparam int WW  = 3 * $clog2(SEGMENTS + 1);
  localparam int RW  = COORD_W + WW;
  localparam int VW  = COORD_W + 2;
  localparam int FB  = COORD_W + 3;
  localparam int PRW = 2 * VW;

  localparam longint DEN2 = longint'(SEGMENTS) * SEGMENTS;
  localparam longint DEN3 = DEN2 * SEGMENTS;
  localparam int     L2   = $clog2(DEN2);
  localparam int     L3   = $clog2(DEN3);
  localparam int     SH2  = (L2 >= 2) ? L2 - 2 : 0;
  localparam int     SH3  = (L3 >= 2) ? L3 - 2 : 0;

  // The dividend is below d * 2^24, so dropping SH low bits leaves 26 bits,
  // and a reciprocal with 27 fraction bits gives the quotient or one less.
  localparam longint RCP2 = (longint'(1) << (SH2 + FB)) / DEN2;
  localparam longint RCP3 = (longint'(1) << (SH3 + FB)) / DEN3;

  localparam logic [VW-1:0] RCP2_W = VW'(RCP2);
  localparam logic [VW-1:0] RCP3_W = VW'(RCP3);
  localparam logic [WW-1:0] DEN_W1 = WW'(1);
  localparam logic [WW-1:0] DEN_W3 = WW'(DEN3);

  typedef enum logic [1:0] {
    D_IDLE,
    D_EST,
    D_MULD,
    D_FIX
  } div_state_t;

  div_state_t         st;
  logic [RW-1:0]      num_x;
  logic [RW-1:0]      num_y;
  logic [WW-1:0]      den;
  bof_flags_t         flags;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [RW-1:0]      qdx;
  logic [RW-1:0]      qdy;
  logic               out_valid;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  bof_flags_t         out_flags;

  logic               byp;
  logic               sel3;
  logic [VW-1:0]      rcp;
  logic [VW-1:0]      vsh_x;
  logic [VW-1:0]      vsh_y;
  logic [PRW-1:0]     est_x;
  logic [PRW-1:0]     est_y;
  logic [RW-1:0]      rem_x;
  logic [RW-1:0]      rem_y;
  logic               inc_x;
  logic               inc_y;
  logic               load;

  // A divisor of one is passed straight through as the estimate.
  assign byp   = (den == DEN_W1);
  assign sel3  = (den == DEN_W3);
  assign rcp   = sel3 ? RCP3_W : RCP2_W;
  assign vsh_x = sel3 ? VW'(num_x >> SH3) : VW'(num_x >> SH2);
  assign vsh_y = sel3 ? VW'(num_y >> SH3) : VW'(num_y >> SH2);
  assign est_x = PRW'(vsh_x) * PRW'(rcp);
  assign est_y = PRW'(vsh_y) * PRW'(rcp);

  assign rem_x = num_x - qdx;
  assign rem_y = num_y - qdy;
  assign inc_x = (rem_x >= RW'(den));
  assign inc_y = (rem_y >= RW'(den));

  assign load     = (st == D_FIX) && (!out_valid || m_axis_tready);
  assign in_ready = (st == D_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= D_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (st)
        D_IDLE: begin
          if (in_valid) begin
            num_x <= in_num_x;
            num_y <= in_num_y;
            den   <= in_den;
            flags <= in_flags;
            st    <= D_EST;
          end
        end
        D_EST: begin
          qx <= byp ? num_x[COORD_W-1:0] : est_x[FB+COORD_W-1:FB];
          qy <= byp ? num_y[COORD_W-1:0] : est_y[FB+COORD_W-1:FB];
          st <= D_MULD;
        end
        D_MULD: begin
          qdx <= RW'(qx) * RW'(den);
          qdy <= RW'(qy) * RW'(den);
          st  <= D_FIX;
        end
        D_FIX: begin
          if (load) begin
            out_x     <= qx + COORD_W'(inc_x);
            out_y     <= qy + COORD_W'(inc_y);
            out_flags <= flags;
            st        <= D_IDLE;
          end
        end
        default: begin
          st <= D_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The dividend carried an offset of half the coordinate range; flipping
  // the top bit of the quotient removes it.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {~out_y[COORD_W-1], out_y[COORD_W-2:0],
                          ~out_x[COORD_W-1], out_x[COORD_W-2:0]};
  assign m_axis_tuser  = out_flags.start;
  assign m_axis_tlast  = out_flags.last;

endmodule
